@@ sv/assert_macros.svh @@
// Assertion macros for the dispatch RTL.
// Each macro checks on the rising clock edge and stays quiet while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequence holds whenever its trigger holds, in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/ehcd_pkg.sv @@
// Shared types, widths and constants for the elevator hall call dispatch block.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package ehcd_pkg;

    localparam int NUM_CARS_DEF = 4;
    localparam int MAX_CARS     = 4;

    localparam int FLOOR_W = 5;
    localparam int DIR_W   = 2;
    localparam int CAR_W   = 2;
    localparam int WT_W    = 12;
    localparam int CNT_W   = 6;
    localparam int MARK_W  = 2;
    localparam int SCORE_W = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PERSONS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR   = 2'd2;

    localparam int LOAD_RESET = 1000;
    localparam int PERS_RESET = 20;
    localparam int TOP_RESET  = 20;

    localparam logic [DIR_W-1:0]  DIR_IDLE  = 2'd0;
    localparam logic [DIR_W-1:0]  DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0]  DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0]  DIR_RSVD  = 2'd3;
    localparam logic [MARK_W-1:0] MARK_BOTH = 2'd3;

    // ceil(2^14 / 5) == ceil(2^15 / 10); exact quotients for any 12-bit value.
    localparam int RECIP      = 3277;
    localparam int RECIP_SH5  = 14;
    localparam int RECIP_SH10 = 15;

    localparam int PEN80 = 10;
    localparam int PEN90 = 50;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [4*MARK_W-1:0]  car_marks;
        logic [4*CNT_W-1:0]   car_counts;
        logic [4*WT_W-1:0]    car_weights;
        logic [4*DIR_W-1:0]   car_dirs;
        logic [4*FLOOR_W-1:0] car_floors;
        logic [CAR_W-1:0]     start_car;
        logic [DIR_W-1:0]     call_dir;
        logic [FLOOR_W-1:0]   call_floor;
    } t_item;

    typedef struct packed {
        logic [WT_W-1:0]    load80;
        logic [WT_W-1:0]    load90;
        logic [CNT_W-1:0]   pers80;
        logic [CNT_W-1:0]   pers90;
        logic [FLOOR_W-1:0] top_floor;
    } t_thresh;

    typedef struct packed {
        logic                             call_ok;
        logic [CAR_W-1:0]                 start_car;
        logic [MAX_CARS-1:0][SCORE_W-1:0] score;
        logic [MAX_CARS-1:0]              busy;
        logic [MAX_CARS-1:0]              under90;
        logic [MAX_CARS-1:0]              match;
        logic [MAX_CARS-1:0]              near;
    } t_scored;

    typedef struct packed {
        logic                call_ok;
        logic [CAR_W-1:0]    pick;
        logic                pick_under90;
        logic [MAX_CARS-1:0] match;
        logic [MAX_CARS-1:0] near;
    } t_picked;

    // Result item, last field in the lowest bits.
    typedef struct packed {
        logic [MAX_CARS-1:0] clear_mask;
        logic [CAR_W-1:0]    chosen_car;
        logic                assigned;
    } t_result;

endpackage

`default_nettype wire

@@ sv/ehcd_cfg.sv @@
// Configuration registers and derived 80% / 90% load and count thresholds.
// Depends on ehcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ehcd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ehcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ehcd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output ehcd_pkg::t_thresh                   o_thr
);
    import ehcd_pkg::*;

    t_thresh r_thr;

    // x - x/5 with the quotient taken from a reciprocal multiply.
    function automatic logic [WT_W-1:0] thr80(input logic [WT_W-1:0] x);
        logic [2*WT_W-1:0] prod;
        prod = (2*WT_W)'(x) * (2*WT_W)'(RECIP);
        return x - WT_W'(prod >> RECIP_SH5);
    endfunction

    function automatic logic [WT_W-1:0] thr90(input logic [WT_W-1:0] x);
        logic [2*WT_W-1:0] prod;
        prod = (2*WT_W)'(x) * (2*WT_W)'(RECIP);
        return x - WT_W'(prod >> RECIP_SH10);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.load80    <= thr80(WT_W'(LOAD_RESET));
            r_thr.load90    <= thr90(WT_W'(LOAD_RESET));
            r_thr.pers80    <= CNT_W'(thr80(WT_W'(PERS_RESET)));
            r_thr.pers90    <= CNT_W'(thr90(WT_W'(PERS_RESET)));
            r_thr.top_floor <= FLOOR_W'(TOP_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WEIGHT_CAP: begin
                    r_thr.load80 <= thr80(i_cfg_wdata[WT_W-1:0]);
                    r_thr.load90 <= thr90(i_cfg_wdata[WT_W-1:0]);
                end
                CFG_MAX_PERSONS: begin
                    r_thr.pers80 <= CNT_W'(thr80(WT_W'(i_cfg_wdata[CNT_W-1:0])));
                    r_thr.pers90 <= CNT_W'(thr90(WT_W'(i_cfg_wdata[CNT_W-1:0])));
                end
                CFG_TOP_FLOOR: begin
                    r_thr.top_floor <= i_cfg_wdata[FLOOR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_thr = r_thr;

endmodule

`default_nettype wire

@@ sv/ehcd_score.sv @@
// Pipeline stage: per-car travel score, load flags and hall call match flags.
// Depends on ehcd_pkg and the thresholds from ehcd_cfg.
`timescale 1ns / 1ps
`default_nettype none

module ehcd_score #(
    parameter int NUM_CARS = ehcd_pkg::NUM_CARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ehcd_pkg::t_thresh i_thr,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ehcd_pkg::t_item   i_item,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ehcd_pkg::t_scored      o_scored
);
    import ehcd_pkg::*;

    logic    r_valid;
    t_scored r_scored;
    t_scored n_scored;

    // Full-span distance: cars sweep between floor 0 and the upper turn point.
    function automatic logic [SCORE_W-1:0] travel(
        input logic [FLOOR_W-1:0] cf,
        input logic [DIR_W-1:0]   cdir,
        input logic [FLOOR_W-1:0] rf,
        input logic [DIR_W-1:0]   rdir,
        input logic [FLOOR_W-1:0] top
    );
        logic [FLOOR_W-1:0]        ut;
        logic signed [SCORE_W-1:0] ut2;
        logic signed [SCORE_W-1:0] cfs;
        logic signed [SCORE_W-1:0] rfs;
        logic [DIR_W-1:0]          eff;
        logic signed [SCORE_W-1:0] res;
        ut  = (top < rf) ? rf : top;
        ut2 = SCORE_W'({ut, 1'b0});
        cfs = SCORE_W'(cf);
        rfs = SCORE_W'(rf);
        eff = cdir;
        if (cdir == DIR_IDLE) begin
            eff = (rf > cf) ? DIR_UP : DIR_DOWN;
        end
        if (rdir == DIR_UP && eff == DIR_UP) begin
            res = (rf >= cf) ? rfs - cfs : ut2 - cfs + rfs;
        end else if (rdir == DIR_DOWN && eff == DIR_DOWN) begin
            res = (rf <= cf) ? cfs - rfs : ut2 - rfs + cfs;
        end else if (rdir == DIR_UP) begin
            res = rfs + cfs;
        end else begin
            res = ut2 - rfs - cfs;
        end
        if (cdir == DIR_IDLE && cf == rf) begin
            res = '0;
        end
        return res;
    endfunction

    always_comb begin
        logic [FLOOR_W-1:0]        cf;
        logic [DIR_W-1:0]          cdir;
        logic [WT_W-1:0]           wt;
        logic [CNT_W-1:0]          cnt;
        logic [MARK_W-1:0]         mark;
        logic signed [SCORE_W-1:0] sc;
        n_scored           = '0;
        n_scored.call_ok   = (i_item.call_dir == DIR_UP) || (i_item.call_dir == DIR_DOWN);
        n_scored.start_car = i_item.start_car;
        for (int i = 0; i < NUM_CARS; i++) begin
            cf   = i_item.car_floors[FLOOR_W*i +: FLOOR_W];
            cdir = i_item.car_dirs[DIR_W*i +: DIR_W];
            wt   = i_item.car_weights[WT_W*i +: WT_W];
            cnt  = i_item.car_counts[CNT_W*i +: CNT_W];
            mark = i_item.car_marks[MARK_W*i +: MARK_W];
            if (cdir == DIR_RSVD) begin
                cdir = DIR_IDLE;
            end
            sc = travel(cf, cdir, i_item.call_floor, i_item.call_dir, i_thr.top_floor);
            if (wt > i_thr.load80 || cnt > i_thr.pers80) begin
                sc = sc + SCORE_W'(PEN80);
            end
            if (wt > i_thr.load90 || cnt > i_thr.pers90) begin
                sc = sc + SCORE_W'(PEN90);
            end
            n_scored.score[i]   = sc;
            n_scored.busy[i]    = (cdir != DIR_IDLE);
            n_scored.under90[i] = (wt < i_thr.load90) && (cnt < i_thr.pers90);
            n_scored.match[i]   = (mark == i_item.call_dir) || (mark == MARK_BOTH);
            n_scored.near[i]    = ((cf >= i_item.call_floor) ? (cf - i_item.call_floor)
                                                             : (i_item.call_floor - cf))
                                  <= FLOOR_W'(1);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_scored <= n_scored;
        end
    end

    assign o_valid  = r_valid;
    assign o_scored = r_scored;

endmodule

`default_nettype wire

@@ sv/ehcd_pick.sv @@
// Pipeline stage: lowest-score car selection, seeded with the start car; equal scores move the pick to a busy car.
// Depends on ehcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ehcd_pick #(
    parameter int NUM_CARS = ehcd_pkg::NUM_CARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ehcd_pkg::t_scored i_scored,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ehcd_pkg::t_picked      o_picked
);
    import ehcd_pkg::*;

    logic    r_valid;
    t_picked r_picked;
    t_picked n_picked;

    always_comb begin
        logic [CAR_W:0]   s;
        logic [CAR_W-1:0] pick;
        // Start candidate reduced modulo the number of cars.
        s = (CAR_W+1)'(i_scored.start_car);
        for (int k = 0; k < MAX_CARS - 1; k++) begin
            if (s >= (CAR_W+1)'(NUM_CARS)) begin
                s = s - (CAR_W+1)'(NUM_CARS);
            end
        end
        pick = s[CAR_W-1:0];
        // An equal score moves the pick only to a car that is not idle.
        for (int i = 0; i < NUM_CARS; i++) begin
            if ($signed(i_scored.score[i]) < $signed(i_scored.score[pick])) begin
                pick = CAR_W'(i);
            end else if (i_scored.score[i] == i_scored.score[pick] && i_scored.busy[i]) begin
                pick = CAR_W'(i);
            end
        end
        n_picked.call_ok      = i_scored.call_ok;
        n_picked.pick         = pick;
        n_picked.pick_under90 = i_scored.under90[pick];
        n_picked.match        = i_scored.match;
        n_picked.near         = i_scored.near;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_picked <= n_picked;
        end
    end

    assign o_valid  = r_valid;
    assign o_picked = r_picked;

endmodule

`default_nettype wire

@@ sv/ehcd_resolve.sv @@
// Output stage: assignment decision and clearing of duplicate hall calls.
// Depends on ehcd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ehcd_resolve #(
    parameter int NUM_CARS = ehcd_pkg::NUM_CARS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ehcd_pkg::t_picked i_picked,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output ehcd_pkg::t_result      o_res
);
    import ehcd_pkg::*;

    localparam logic [MAX_CARS-1:0] CAR_MASK = MAX_CARS'((1 << NUM_CARS) - 1);

    logic    r_valid;
    t_result r_res;
    t_result n_res;
    logic    chosen_ok;
    logic    winner_kept;
    logic    mask_ok;

    always_comb begin
        logic stop;
        n_res = '0;
        stop  = 1'b0;
        if (i_picked.call_ok) begin
            n_res.chosen_car = i_picked.pick;
            if (i_picked.pick_under90) begin
                n_res.assigned = 1'b1;
                // Cars are examined in index order; the first matching car that is
                // the winner or within one floor suppresses the call and ends the scan.
                for (int i = 0; i < NUM_CARS; i++) begin
                    if (!stop && i_picked.match[i]) begin
                        if (CAR_W'(i) == i_picked.pick || i_picked.near[i]) begin
                            n_res.assigned = 1'b0;
                            stop           = 1'b1;
                        end else begin
                            n_res.clear_mask[i] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    assign chosen_ok   = (CAR_W+1)'(r_res.chosen_car) < (CAR_W+1)'(NUM_CARS);
    assign winner_kept = !r_res.clear_mask[r_res.chosen_car];
    assign mask_ok     = (r_res.clear_mask & ~CAR_MASK) == '0;

    `ASSERT_IMPL(a_chosen_in_range, i_clk, i_rst_n, r_valid, chosen_ok, "chosen car out of range")
    `ASSERT_IMPL(a_winner_not_cleared, i_clk, i_rst_n, r_valid, winner_kept, "winner cleared")
    `ASSERT_IMPL(a_mask_in_group, i_clk, i_rst_n, r_valid, mask_ok, "clear mask outside group")

endmodule

`default_nettype wire

@@ sv/elevator_hall_call_dispatch.sv @@
// Elevator hall call dispatch: top level with input register and stage wiring.
// Depends on ehcd_pkg, ehcd_cfg, ehcd_score, ehcd_pick and ehcd_resolve.
//
// Usage:
//   Calls enter on the slave stream (i_s_tvalid / o_s_tready / i_s_tdata); one
//   call transfers per cycle when both are high. Each call yields exactly one
//   result on the master stream (o_m_tvalid / i_m_tready / o_m_tdata).
//   Configuration is a plain write port: i_cfg_we, i_cfg_idx (0 weight capacity,
//   1 max_persons, 2 top_floor), i_cfg_wdata; write only while no call is in
//   flight. Load thresholds are derived at write time.
//   The result passes through the input register, score stage, pick stage
//   and result register.
//   Throughput: one call per cycle while the receiver takes results, set by
//   the four-stage register pipeline with one register stage per step.
//   Reset (synchronous, active low) empties the pipeline and loads a weight
//   capacity of 1000, max_persons 20 and top_floor 20.
//   When the receiver stalls, the result is held; each stage keeps taking
//   calls until it is full, so up to four calls can wait inside the block.
`timescale 1ns / 1ps
`default_nettype none

module elevator_hall_call_dispatch #(
    parameter int NUM_CARS = ehcd_pkg::NUM_CARS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [ehcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [ehcd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // call_floor[4:0], call_dir[6:5], start_car[8:7], car_floors[28:9],
    // car_dirs[36:29], car_weights[84:37], car_counts[108:85], car_marks[116:109]
    input  wire logic [ehcd_pkg::IN_DATA_W-1:0]  i_s_tdata,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // assigned[0], chosen_car[2:1], clear_mask[6:3]
    output logic [ehcd_pkg::OUT_DATA_W-1:0]      o_m_tdata
);
    import ehcd_pkg::*;

    logic    r_in_valid;
    t_item   r_item;
    t_thresh thr;
    logic    score_ready;
    logic    score_valid;
    t_scored scored;
    logic    pick_ready;
    logic    pick_valid;
    t_picked picked;
    logic    res_ready;
    t_result res;

    ehcd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_thr       (thr)
    );

    assign o_s_tready = !r_in_valid || score_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item <= i_s_tdata[$bits(t_item)-1:0];
        end
    end

    ehcd_score #(.NUM_CARS(NUM_CARS)) u_score (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_thr    (thr),
        .i_valid  (r_in_valid),
        .o_ready  (score_ready),
        .i_item   (r_item),
        .o_valid  (score_valid),
        .i_ready  (pick_ready),
        .o_scored (scored)
    );

    ehcd_pick #(.NUM_CARS(NUM_CARS)) u_pick (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (score_valid),
        .o_ready  (pick_ready),
        .i_scored (scored),
        .o_valid  (pick_valid),
        .i_ready  (res_ready),
        .o_picked (picked)
    );

    ehcd_resolve #(.NUM_CARS(NUM_CARS)) u_resolve (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pick_valid),
        .o_ready  (res_ready),
        .i_picked (picked),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_res    (res)
    );

    assign o_m_tdata = {(OUT_DATA_W - $bits(t_result))'(0), res};

endmodule

`default_nettype wire
